[rtl/cbc_pkg.sv]
// shared types and constants for the cartridge bank controller
// no dependencies
package cbc_pkg;

  localparam int RamBytes    = 32768;
  localparam int RomBankBits = 14;
  localparam int AddrW       = 16;
  localparam int RomAddrW    = 21;
  localparam int BankW       = 7;
  localparam int RamBankW    = 2;
  localparam int RamOffW     = 13;
  localparam int RamIdxW     = RamBankW + RamOffW;
  localparam int QDepth      = 4;
  localparam int QPtrW       = 2;

  localparam logic [1:0] KindPlain   = 2'd0;
  localparam logic [1:0] KindFiveTwo = 2'd1;
  localparam logic [1:0] KindSeven   = 2'd2;

  localparam logic [1:0] CfgKind      = 2'd0;
  localparam logic [1:0] CfgBankCount = 2'd1;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_ADDR    = 3'd1,
    ERR_BANK    = 3'd2,
    ERR_SELECT  = 3'd3,
    ERR_FEATURE = 3'd4
  } err_e;

  typedef struct packed {
    target_e               target;
    logic [RomAddrW-1:0]   rom_address;
    logic                  ram_wr;
    logic [RamIdxW-1:0]    ram_index;
    logic [7:0]            wdata;
    err_e                  error;
  } cmd_t;

  typedef struct packed {
    target_e               target;
    logic [RomAddrW-1:0]   rom_address;
    logic [7:0]            read_data;
    logic                  ram_written;
    err_e                  error;
  } res_t;

endpackage

[rtl/cbc_front.sv]
// front end: request decode, bank registers and configuration registers
// depends on cbc_pkg
module cbc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                push_i,
  input  logic                opcode_i,
  input  logic [15:0]         bus_address_i,
  input  logic [7:0]          write_data_i,
  output cbc_pkg::cmd_t       cmd_o
);
  import cbc_pkg::*;

  logic [1:0]          kind_q;
  logic [7:0]          bank_count_q;
  logic [BankW-1:0]    rom_bank_q, rom_bank_d;
  logic [RamBankW-1:0] ram_bank_q, ram_bank_d;

  logic [BankW-1:0]    bank_sel;
  logic [BankW-1:0]    bank_lo, bank_hi;
  logic [BankW-1:0]    bank_seven;
  cmd_t                rom_cmd;
  cmd_t                cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= KindPlain;
      bank_count_q <= 8'd128;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgKind:      kind_q       <= cfg_data_i[1:0];
        CfgBankCount: bank_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= BankW'(1);
      ram_bank_q <= '0;
    end else if (push_i) begin
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
    end
  end

  // banked window bank, with the zero-low-bits bump folded in
  always_comb begin
    bank_sel   = (kind_q == KindFiveTwo || kind_q == KindSeven) ? rom_bank_q : BankW'(1);
    bank_lo    = {rom_bank_q[6:5], write_data_i[4:0]};
    bank_hi    = {write_data_i[1:0], rom_bank_q[4:0]};
    bank_seven = write_data_i[6:0];
    if (bank_lo[4:0] == 5'd0) bank_lo[0] = 1'b1;
    if (bank_hi[4:0] == 5'd0) bank_hi[0] = 1'b1;
    if (bank_seven == '0) bank_seven[0] = 1'b1;
  end

  // read path shared by all modes below 0x8000
  always_comb begin
    rom_cmd             = cmd_t'('0);
    rom_cmd.target      = TGT_NONE;
    rom_cmd.error       = ERR_OK;
    rom_cmd.wdata       = write_data_i;
    if (bus_address_i[15]) begin
      rom_cmd.error = ERR_ADDR;
    end else if (bus_address_i[14] == 1'b0) begin
      rom_cmd.target      = TGT_ROM;
      rom_cmd.rom_address = RomAddrW'(bus_address_i);
    end else if ({1'b0, bank_sel} >= bank_count_q) begin
      rom_cmd.error = ERR_BANK;
    end else begin
      rom_cmd.target      = TGT_ROM;
      rom_cmd.rom_address = {bank_sel, bus_address_i[RomBankBits-1:0]};
    end
  end

  always_comb begin
    cmd            = cmd_t'('0);
    cmd.target     = TGT_NONE;
    cmd.error      = ERR_OK;
    cmd.wdata      = write_data_i;
    cmd.ram_index  = {ram_bank_q, bus_address_i[RamOffW-1:0]};
    rom_bank_d     = rom_bank_q;
    ram_bank_d     = ram_bank_q;
    case (kind_q)
      KindFiveTwo: begin
        if (!opcode_i) begin
          cmd = rom_cmd;
        end else if (bus_address_i inside {[16'h2000:16'h3FFF]}) begin
          rom_bank_d = bank_lo;
        end else if (bus_address_i inside {[16'h4000:16'h5FFF]}) begin
          rom_bank_d = bank_hi;
        end else if (bus_address_i inside {[16'hA000:16'hBFFF]}) begin
          cmd.error = ERR_FEATURE;
        end else begin
          cmd.error = ERR_ADDR;
        end
      end
      KindSeven: begin
        if (!opcode_i) begin
          if (!bus_address_i[15]) begin
            cmd = rom_cmd;
          end else if (bus_address_i inside {[16'hA000:16'hBFFF]}) begin
            cmd.target = TGT_RAM;
          end else begin
            cmd.error = ERR_ADDR;
          end
        end else if (bus_address_i < 16'h2000) begin
          cmd.error = ERR_OK;
        end else if (bus_address_i < 16'h4000) begin
          rom_bank_d = bank_seven;
        end else if (bus_address_i < 16'h6000) begin
          if (write_data_i <= 8'd3) begin
            ram_bank_d = write_data_i[RamBankW-1:0];
          end else if (write_data_i inside {[8'h08:8'h0C]}) begin
            cmd.error = ERR_FEATURE;
          end else begin
            cmd.error = ERR_SELECT;
          end
        end else if (bus_address_i < 16'h8000) begin
          cmd.error = ERR_FEATURE;
        end else if (bus_address_i inside {[16'hA000:16'hBFFF]}) begin
          cmd.ram_wr = 1'b1;
        end else begin
          cmd.error = ERR_ADDR;
        end
      end
      default: begin
        if (!opcode_i) begin
          cmd = rom_cmd;
        end else if (bus_address_i inside {[16'h2000:16'h3FFF]}) begin
          if (write_data_i > 8'd1) cmd.error = ERR_SELECT;
        end else begin
          cmd.error = ERR_ADDR;
        end
      end
    endcase
  end

  assign cmd_o = cmd;

endmodule

[rtl/cbc_fifo.sv]
// short command queue between the decode front end and the ram back end
// depends on cbc_pkg
module cbc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbc_pkg::cmd_t  push_data_i,
  input  logic           pop_i,
  output cbc_pkg::cmd_t  head_o,
  output logic           valid_o,
  output logic           full_o
);
  import cbc_pkg::*;

  cmd_t               entry_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QPtrW+1)'(QDepth));

endmodule

[rtl/cbc_back.sv]
// back end: banked ram with clearing pass, ram stage and output register
// depends on cbc_pkg
module cbc_back #(
  parameter int RAM_BYTES = cbc_pkg::RamBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbc_pkg::cmd_t  head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cbc_pkg::res_t  res_o
);
  import cbc_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [AW-1:0] ClrLast = AW'(RAM_BYTES - 1);

  logic [7:0]    mem [RAM_BYTES];
  logic [7:0]    rd_data_q;
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  cmd_t          s1_q;
  logic          s1_valid_q;
  res_t          out_q, out_d;
  logic          out_valid_q;

  logic          s1_adv;
  logic          pop;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop    = head_valid_i && !clearing_q && (!s1_valid_q || s1_adv);

  assign mem_addr  = clearing_q ? clr_addr_q : head_i.ram_index[AW-1:0];
  assign mem_we    = clearing_q || (pop && head_i.ram_wr);
  assign mem_wdata = clearing_q ? 8'd0 : head_i.wdata;
  assign mem_re    = pop && (head_i.target == TGT_RAM);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_addr];
  end

  // zero fill after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ClrLast) clearing_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) s1_q <= head_i;
  end

  always_comb begin
    out_d             = out_q;
    out_d.target      = s1_q.target;
    out_d.rom_address = s1_q.rom_address;
    out_d.read_data   = (s1_q.target == TGT_RAM) ? rd_data_q : 8'd0;
    out_d.ram_written = s1_q.ram_wr;
    out_d.error       = s1_q.error;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign pop_o       = pop;
  assign clearing_o  = clearing_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[rtl/cartridge_bank_controller_top.sv]
// top level of the cartridge bank controller: front end, queue, back end
// after reset the ram is zero filled with input stalled
// one request per cycle sustained while the output is not stalled; after its request
// is taken a result passes the queue stage, ram read stage and output register
// rate is set by the single ram port, at most one access per request
// depends on cbc_pkg, cbc_front, cbc_fifo, cbc_back
module cartridge_bank_controller_top #(
  parameter int RAM_BYTES = cbc_pkg::RamBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  target_o,
  output logic [20:0] rom_address_o,
  output logic [7:0]  read_data_o,
  output logic        ram_written_o,
  output logic [2:0]  error_code_o
);
  import cbc_pkg::*;

  cmd_t cmd, head;
  res_t res;
  logic push, pop, q_valid, q_full, clearing;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = clearing || q_full;
  assign push        = in_valid_i && !in_stall_o;

  cbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .opcode_i      (opcode_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .cmd_o         (cmd)
  );

  cbc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  cbc_back #(
    .RAM_BYTES (RAM_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign target_o      = res.target;
  assign rom_address_o = res.rom_address;
  assign read_data_o   = res.read_data;
  assign ram_written_o = res.ram_written;
  assign error_code_o  = res.error;

  a_ram_data_only_on_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o != TGT_RAM) |-> (read_data_o == 8'd0))
    else $error("read data without ram target");

  a_write_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ram_written_o |-> (target_o == TGT_NONE) && (error_code_o == ERR_OK))
    else $error("ram write with target or error");

  a_rom_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == TGT_ROM) |-> (error_code_o == ERR_OK))
    else $error("rom fetch with error");

  a_no_output_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o && !q_valid)
    else $error("request in flight during ram clear");

endmodule
